[hw/rtl/frame_stats_window_average_top_macros.svh]
// Assertion macros shared by the frame statistics block.
`ifndef FRAME_STATS_WINDOW_AVERAGE_TOP_MACROS_SVH
`define FRAME_STATS_WINDOW_AVERAGE_TOP_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define FSWA_ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FSWA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FSWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/fswa_pkg.sv]
// Shared constants and payload types of the frame statistics block.
`timescale 1ns / 1ps

package fswa_pkg;

   localparam int VAL_W  = 17;
   localparam int SLOT_W = 7;
   localparam int QUO_W  = 17;

   localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic [VAL_W-1:0]  sample;
      logic [SLOT_W-1:0] frame_slot;
      logic              last_sample;
   } req_payload_type;

   typedef struct packed {
      logic [VAL_W-1:0] frame_mean;
      logic [VAL_W-1:0] frame_min;
      logic [VAL_W-1:0] frame_max;
      logic [VAL_W-1:0] window_mean;
      logic [VAL_W-1:0] window_min;
      logic [VAL_W-1:0] window_max;
      logic             empty_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [VAL_W-1:0] mean;
      logic [VAL_W-1:0] minimum;
      logic [VAL_W-1:0] maximum;
   } hist_entry_type;

endpackage

[hw/rtl/fswa_stream_if.sv]
// Valid/ready stream interface that carries one payload per transaction.
`timescale 1ns / 1ps

interface fswa_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/fswa_divider.sv]
// Restoring divider that produces a 17-bit quotient, one bit per cycle.
`timescale 1ns / 1ps

module fswa_divider
   import fswa_pkg::*;
#(
   parameter int DIVIDEND_W = 41,
   parameter int DIVISOR_W  = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [QUO_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [QUO_W-1:0]     low_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, low_ff[QUO_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= STEP_W'(QUO_W);
      end else if (run_ff) begin
         step_ff <= step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DIVISOR_W'(dividend >> QUO_W);
         low_ff <= dividend[QUO_W-1:0];
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/frame_stats_window_average_top.sv]
// Top level of the frame statistics block with history window averages.
//
//   Channel | Direction | Carries
//   --------+-----------+-----------------------------------------------
//   req_if  | in        | sample, frame_slot, last_sample
//   rsp_if  | out       | frame and window mean/min/max, empty_frame
//
// A sample that is not the last of its frame updates the running statistics and leaves the block idle.
// A last sample runs through these steps in order: the frame mean in the divider, one store
// step, the history read sweep, three steps for the window averages on one shared multiplier
// and one step that loads the result.
// Reset clears the running statistics and the history valid bits at once.
// The load step stalls while the previous transaction still waits in the output register.
`timescale 1ns / 1ps
`include "frame_stats_window_average_top_macros.svh"

module frame_stats_window_average_top
   import fswa_pkg::*;
#(
   parameter int HISTORY_DEPTH     = 64,
   parameter int WINDOW_LENGTH     = 32,
   parameter int MAX_FRAME_SAMPLES = 1048576
) (
   input  logic          clock,
   input  logic          reset,
   fswa_stream_if.sink   req_if,
   fswa_stream_if.source rsp_if
);

   localparam int CNT_W      = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W      = CNT_W + VAL_W;
   localparam int WIN_W      = $clog2(WINDOW_LENGTH + 1);
   localparam int ACC_W      = VAL_W + WIN_W;
   localparam int IDX_W      = $clog2(HISTORY_DEPTH);
   localparam int RCP_SHIFT  = ACC_W + WIN_W;
   localparam int RCP_W      = RCP_SHIFT + 1;
   localparam int PROD_W     = ACC_W + RCP_W;

   localparam logic [CNT_W-1:0]     MAX_COUNT  = CNT_W'(MAX_FRAME_SAMPLES);
   localparam logic [WIN_W-1:0]     WIN_COUNT  = WIN_W'(WINDOW_LENGTH);
   localparam logic [RCP_W-1:0]     WIN_RECIP  =
      RCP_W'(((64'd1 << RCP_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));
   localparam logic [IDX_W-1:0]     WIN_FIRST  = IDX_W'(HISTORY_DEPTH - WINDOW_LENGTH);
   localparam logic [8:0]           SLOT_LIMIT = 9'(HISTORY_DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DIV_MEAN = 8'b0000_0010,
      ST_STORE    = 8'b0000_0100,
      ST_SWEEP    = 8'b0000_1000,
      ST_DIV_WMEAN = 8'b0001_0000,
      ST_DIV_WMIN = 8'b0010_0000,
      ST_DIV_WMAX = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type             state_ff;
   state_type             state_in;

   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [VAL_W-1:0]      min_ff;
   logic [VAL_W-1:0]      max_ff;

   logic [VAL_W-1:0]      sample_sat;
   logic [SUM_W-1:0]      sum_in;
   logic [CNT_W-1:0]      count_in;
   logic [VAL_W-1:0]      min_in;
   logic [VAL_W-1:0]      max_in;
   logic                  flag_in;

   logic [VAL_W-1:0]      job_min_ff;
   logic [VAL_W-1:0]      job_max_ff;
   logic [SLOT_W-1:0]     job_slot_ff;
   logic                  job_flag_ff;
   logic [VAL_W-1:0]      mean_ff;

   hist_entry_type        hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_valid_ff;
   hist_entry_type        rd_data_ff;
   logic                  rd_hit_ff;
   logic [IDX_W-1:0]      rd_addr_ff;
   logic [WIN_W-1:0]      rd_cnt_ff;
   logic                  rd_pend_ff;
   logic                  rd_issue;
   logic                  sweep_done;
   logic [8:0]            slot_wide;
   logic [8:0]            slot_less;
   logic                  slot_ok;

   logic [ACC_W-1:0]      acc_mean_ff;
   logic [ACC_W-1:0]      acc_min_ff;
   logic [ACC_W-1:0]      acc_max_ff;
   logic [VAL_W-1:0]      win_mean_ff;
   logic [VAL_W-1:0]      win_min_ff;
   logic [VAL_W-1:0]      win_max_ff;
   logic [ACC_W-1:0]      win_operand;
   logic [PROD_W-1:0]     win_product;
   logic [VAL_W-1:0]      win_quotient;

   logic                  div_start;
   logic                  div_done;
   logic [QUO_W-1:0]      div_quotient;

   rsp_payload_type       rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_free;
   logic                  req_accept;
   logic                  req_last;

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign req_accept     = req_if.valid && req_if.ready;
   assign req_last       = req_accept && req_if.payload.last_sample;
   assign rsp_free       = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      sample_sat = (req_if.payload.sample > ONE_Q16) ? ONE_Q16 : req_if.payload.sample;
      sum_in     = sum_ff;
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      if (count_ff < MAX_COUNT) begin
         sum_in   = sum_ff + SUM_W'(sample_sat);
         count_in = count_ff + 1'b1;
         if (sample_sat > max_ff) begin
            max_in = sample_sat;
         end
         if ((sample_sat != '0) && (sample_sat < min_ff)) begin
            min_in = sample_sat;
         end
      end
      flag_in = (count_in == '0) || (count_in >= MAX_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         min_ff   <= ONE_Q16;
         max_ff   <= '0;
      end else if (req_last) begin
         sum_ff   <= '0;
         count_ff <= '0;
         min_ff   <= ONE_Q16;
         max_ff   <= '0;
      end else if (req_accept) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_last) begin
         job_min_ff  <= min_in;
         job_max_ff  <= max_in;
         job_slot_ff <= req_if.payload.frame_slot;
         job_flag_ff <= flag_in;
      end
   end

   assign div_start = req_last;

   fswa_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      unique case (state_ff)
         ST_DIV_WMEAN: win_operand = acc_mean_ff;
         ST_DIV_WMIN:  win_operand = acc_min_ff;
         default:      win_operand = acc_max_ff;
      endcase
      win_product  = PROD_W'(win_operand) * PROD_W'(WIN_RECIP);
      win_quotient = win_product[RCP_SHIFT +: VAL_W];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_last) state_in = ST_DIV_MEAN;
         ST_DIV_MEAN:  if (div_done) state_in = ST_STORE;
         ST_STORE:     state_in = ST_SWEEP;
         ST_SWEEP:     if (sweep_done) state_in = ST_DIV_WMEAN;
         ST_DIV_WMEAN: state_in = ST_DIV_WMIN;
         ST_DIV_WMIN:  state_in = ST_DIV_WMAX;
         ST_DIV_WMAX:  state_in = ST_DONE;
         ST_DONE:      if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV_MEAN) && div_done) begin
         mean_ff <= job_flag_ff ? '0 : div_quotient;
      end
      if (state_ff == ST_DIV_WMEAN) begin
         win_mean_ff <= win_quotient;
      end
      if (state_ff == ST_DIV_WMIN) begin
         win_min_ff <= win_quotient;
      end
      if (state_ff == ST_DIV_WMAX) begin
         win_max_ff <= win_quotient;
      end
   end

   assign slot_wide = {2'b00, job_slot_ff};
   assign slot_less = slot_wide - 9'd1;
   assign slot_ok   = (slot_wide != '0) && (slot_wide <= SLOT_LIMIT);

   assign rd_issue   = (state_ff == ST_SWEEP) && (rd_cnt_ff != WIN_COUNT);
   assign sweep_done = (state_ff == ST_SWEEP) && (rd_cnt_ff == WIN_COUNT) && !rd_pend_ff;

   always_ff @(posedge clock) begin
      if ((state_ff == ST_STORE) && slot_ok) begin
         hist_mem[slot_less[IDX_W-1:0]] <= '{mean: mean_ff, minimum: job_min_ff,
                                             maximum: job_max_ff};
      end
      if (rd_issue) begin
         rd_data_ff <= hist_mem[rd_addr_ff];
         rd_hit_ff  <= hist_valid_ff[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
      end else if ((state_ff == ST_STORE) && slot_ok) begin
         hist_valid_ff[slot_less[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         rd_pend_ff <= 1'b0;
         rd_addr_ff <= '0;
      end else if (state_ff == ST_STORE) begin
         rd_cnt_ff  <= '0;
         rd_pend_ff <= 1'b0;
         rd_addr_ff <= WIN_FIRST;
      end else begin
         rd_pend_ff <= rd_issue;
         if (rd_issue) begin
            rd_cnt_ff  <= rd_cnt_ff + 1'b1;
            rd_addr_ff <= rd_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         acc_mean_ff <= '0;
         acc_min_ff  <= '0;
         acc_max_ff  <= '0;
      end else if ((state_ff == ST_SWEEP) && rd_pend_ff && rd_hit_ff) begin
         acc_mean_ff <= acc_mean_ff + ACC_W'(rd_data_ff.mean);
         acc_min_ff  <= acc_min_ff + ACC_W'(rd_data_ff.minimum);
         acc_max_ff  <= acc_max_ff + ACC_W'(rd_data_ff.maximum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_data_ff.frame_mean  <= mean_ff;
         rsp_data_ff.frame_min   <= job_min_ff;
         rsp_data_ff.frame_max   <= job_max_ff;
         rsp_data_ff.window_mean <= win_mean_ff;
         rsp_data_ff.window_min  <= win_min_ff;
         rsp_data_ff.window_max  <= win_max_ff;
         rsp_data_ff.empty_frame <= job_flag_ff;
      end
   end

   `FSWA_ASSERT_NEXT(a_last_div, req_last, state_ff == ST_DIV_MEAN, "Divide not started.")
   `FSWA_ASSERT_IMPLIES(a_rsp, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "Stray result.")
   `FSWA_ASSERT_HOLDS(a_sweep_bound, rd_cnt_ff <= WIN_COUNT, "Sweep past window.")
   `FSWA_ASSERT_HOLDS(a_min_range, (min_ff != '0) && (min_ff <= ONE_Q16), "Minimum left range.")

endmodule

[sim/tb_top.sv]
// Self-checking testbench of the frame statistics block with its history window averages.
`timescale 1ns / 1ps

module tb_top
   import fswa_pkg::*;
();

   localparam int HIST_DEPTH     = 64;
   localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);
   localparam int WIN_LEN        = 32;
   localparam int FRAME_LIMIT    = 1048576;
   localparam int QUIET_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PHASE_ITEMS    = 225;
   localparam int MAX_REPORTS    = 100;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type result;
   } stim_row_type;

   logic clock;
   logic reset;

   fswa_stream_if #(.payload_type(req_payload_type)) req_ch ();
   fswa_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   frame_stats_window_average_top #(
      .HISTORY_DEPTH    (HIST_DEPTH),
      .WINDOW_LENGTH    (WIN_LEN),
      .MAX_FRAME_SAMPLES(FRAME_LIMIT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   logic [36:0]      acc_sum;
   logic [20:0]      acc_count;
   logic [VAL_W-1:0] low_val;
   logic [VAL_W-1:0] high_val;
   logic [VAL_W-1:0] hist_mean [HIST_DEPTH];
   logic [VAL_W-1:0] hist_min [HIST_DEPTH];
   logic [VAL_W-1:0] hist_max [HIST_DEPTH];

   rsp_payload_type stats_expected[$];
   stim_row_type    directed_rows[$];
   int              mismatches;
   int              send_idle_pct;
   int              stall_pct;
   int              quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      if (mismatches < MAX_REPORTS)
         $display("%0t ns %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic rsp_payload_type make_stats(
      input logic [VAL_W-1:0] f_mean, input logic [VAL_W-1:0] f_min,
      input logic [VAL_W-1:0] f_max, input logic [VAL_W-1:0] w_mean,
      input logic [VAL_W-1:0] w_min, input logic [VAL_W-1:0] w_max, input bit empty);
      rsp_payload_type rec;
      rec.frame_mean  = f_mean;
      rec.frame_min   = f_min;
      rec.frame_max   = f_max;
      rec.window_mean = w_mean;
      rec.window_min  = w_min;
      rec.window_max  = w_max;
      rec.empty_frame = empty;
      return rec;
   endfunction

   task automatic clear_frame_stats();
      acc_sum   = '0;
      acc_count = '0;
      low_val   = ONE_Q16;
      high_val  = '0;
   endtask

   task automatic advance_frame_stats(input req_payload_type item, output bit emitted,
                                      output rsp_payload_type rec);
      logic [VAL_W-1:0]      smp;
      logic [VAL_W-1:0]      mean;
      logic [31:0]           sum_mean;
      logic [31:0]           sum_min;
      logic [31:0]           sum_max;
      logic [HIST_IDX_W-1:0] slot_idx;
      bit                    flagged;
      smp = (item.sample > ONE_Q16) ? ONE_Q16 : item.sample;
      if (acc_count < FRAME_LIMIT) begin
         acc_sum   = acc_sum + 37'(smp);
         acc_count = acc_count + 1'b1;
         if (smp > high_val)
            high_val = smp;
         if (smp != '0 && smp < low_val)
            low_val = smp;
      end
      emitted = item.last_sample;
      rec = '0;
      if (item.last_sample) begin
         flagged = (acc_count == '0) || (acc_count >= FRAME_LIMIT);
         mean = flagged ? '0 : VAL_W'(acc_sum / 37'(acc_count));
         if (item.frame_slot >= 1 && item.frame_slot <= HIST_DEPTH) begin
            slot_idx            = HIST_IDX_W'(item.frame_slot - 7'd1);
            hist_mean[slot_idx] = mean;
            hist_min[slot_idx]  = low_val;
            hist_max[slot_idx]  = high_val;
         end
         sum_mean = '0;
         sum_min  = '0;
         sum_max  = '0;
         for (int k = HIST_DEPTH - WIN_LEN; k < HIST_DEPTH; k++) begin
            sum_mean += 32'(hist_mean[k]);
            sum_min  += 32'(hist_min[k]);
            sum_max  += 32'(hist_max[k]);
         end
         rec = make_stats(mean, low_val, high_val, VAL_W'(sum_mean / WIN_LEN),
                          VAL_W'(sum_min / WIN_LEN), VAL_W'(sum_max / WIN_LEN), flagged);
         clear_frame_stats();
      end
   endtask

   task automatic send_sample(input req_payload_type item, input bit typed,
                              input rsp_payload_type typed_result);
      bit              emitted;
      rsp_payload_type rec;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      advance_frame_stats(item, emitted, rec);
      if (emitted)
         stats_expected.push_back(typed ? typed_result : rec);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (stats_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_row(input logic [VAL_W-1:0] smp, input logic [SLOT_W-1:0] slot,
                          input bit last, input bit typed, input rsp_payload_type res);
      stim_row_type row;
      row.item.sample      = smp;
      row.item.frame_slot  = slot;
      row.item.last_sample = last;
      row.typed            = typed;
      row.result           = res;
      directed_rows.push_back(row);
   endtask

   task automatic compare_stats(input rsp_payload_type got, input rsp_payload_type want);
      if (got.frame_mean !== want.frame_mean)
         report_mismatch("frame_mean", got.frame_mean, want.frame_mean);
      if (got.frame_min !== want.frame_min)
         report_mismatch("frame_min", got.frame_min, want.frame_min);
      if (got.frame_max !== want.frame_max)
         report_mismatch("frame_max", got.frame_max, want.frame_max);
      if (got.window_mean !== want.window_mean)
         report_mismatch("window_mean", got.window_mean, want.window_mean);
      if (got.window_min !== want.window_min)
         report_mismatch("window_min", got.window_min, want.window_min);
      if (got.window_max !== want.window_max)
         report_mismatch("window_max", got.window_max, want.window_max);
      if (got.empty_frame !== want.empty_frame)
         report_mismatch("empty_frame", VAL_W'(got.empty_frame), VAL_W'(want.empty_frame));
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (stats_expected.size() == 0)
               report_mismatch("result with none expected", '0, '0);
            else
               compare_stats(rsp_ch.payload, stats_expected.pop_front());
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("frame_stats_window_average_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      req_payload_type item;
      rsp_payload_type none;
      int              sent;
      int              frame_len;
      int              pick;
      int              send_pcts [4];
      int              stall_pcts [4];

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      mismatches     = 0;
      quiet_cycles   = 0;
      none           = '0;
      send_pcts      = '{0, 70, 0, 32};
      stall_pcts     = '{0, 0, 70, 32};

      clear_frame_stats();
      for (int k = 0; k < HIST_DEPTH; k++) begin
         hist_mean[k] = '0;
         hist_min[k]  = '0;
         hist_max[k]  = '0;
      end

      add_row(17'd0, 7'd0, 1'b1, 1'b1,
              make_stats(17'd0, 17'd65536, 17'd0, 17'd0, 17'd0, 17'd0, 1'b0));
      add_row(17'h1FFFF, 7'd64, 1'b1, 1'b1,
              make_stats(17'd65536, 17'd65536, 17'd65536, 17'd2048, 17'd2048, 17'd2048,
                         1'b0));
      add_row(17'd1, 7'd33, 1'b1, 1'b1,
              make_stats(17'd1, 17'd1, 17'd1, 17'd2048, 17'd2048, 17'd2048, 1'b0));
      add_row(17'd65536, 7'd5, 1'b0, 1'b0, none);
      add_row(17'd0, 7'd127, 1'b1, 1'b1,
              make_stats(17'd32768, 17'd65536, 17'd65536, 17'd2048, 17'd2048, 17'd2048,
                         1'b0));
      add_row(17'd65537, 7'd0, 1'b0, 1'b0, none);
      add_row(17'd2, 7'd65, 1'b1, 1'b1,
              make_stats(17'd32769, 17'd2, 17'd65536, 17'd2048, 17'd2048, 17'd2048, 1'b0));
      add_row(17'h0AAAA, 7'd0, 1'b0, 1'b0, none);
      add_row(17'h05555, 7'd0, 1'b0, 1'b0, none);
      add_row(17'h0FFFF, 7'd32, 1'b1, 1'b0, none);
      add_row(17'h00001, 7'd1, 1'b1, 1'b0, none);
      add_row(17'h10000, 7'd64, 1'b1, 1'b0, none);
      add_row(17'h0FFFF, 7'd48, 1'b0, 1'b0, none);
      add_row(17'h08000, 7'd48, 1'b1, 1'b0, none);
      add_row(17'h15555, 7'h55, 1'b0, 1'b0, none);
      add_row(17'h0AAAA, 7'h2A, 1'b1, 1'b0, none);
      add_row(17'd0, 7'd40, 1'b1, 1'b0, none);
      add_row(17'h1FFFF, 7'd63, 1'b0, 1'b0, none);
      add_row(17'h1FFFF, 7'd63, 1'b1, 1'b0, none);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      wait_results_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pcts[phase];
         stall_pct     = stall_pcts[phase];
         sent          = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80)
               frame_len = $urandom_range(6, 1);
            else if (pick < 95)
               frame_len = $urandom_range(40, 7);
            else
               frame_len = 1;
            for (int i = 0; i < frame_len; i++) begin
               pick = $urandom_range(99);
               if (pick < 10)
                  item.sample = '0;
               else if (pick < 20)
                  item.sample = 17'($urandom_range(131071, 65537));
               else if (pick < 25)
                  item.sample = ONE_Q16;
               else
                  item.sample = 17'($urandom_range(65535, 1));
               pick = $urandom_range(99);
               if (pick < 70)
                  item.frame_slot = 7'($urandom_range(64, 33));
               else if (pick < 90)
                  item.frame_slot = 7'($urandom_range(32, 1));
               else if (pick < 94)
                  item.frame_slot = '0;
               else
                  item.frame_slot = 7'($urandom_range(127, 65));
               item.last_sample = (i == frame_len - 1);
               send_sample(item, 1'b0, none);
               sent++;
            end
         end
         wait_results_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("frame_stats_window_average_top: match");
      else
         $display("frame_stats_window_average_top: mismatch");
      $finish;
   end

endmodule
